>>> rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the least-recently-used key/value store.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int ENTRIES_DEFAULT = 16;
  localparam int KEY_W           = 32;
  localparam int VAL_W           = 32;
  localparam int CAP_W           = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic search;
    logic update;
    logic result;
  } lkv_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_put;
  } lkv_status_t;

endpackage

>>> rtl/lkv_if.sv
// ----------------------------------------------------------------------------
// lkv_if
// Channel interfaces: request, response and capacity write.
// ----------------------------------------------------------------------------
interface lkv_req_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [lkv_pkg::KEY_W-1:0]    key;
  logic signed [lkv_pkg::VAL_W-1:0]    value;

  modport source (output valid, output action, output key, output value, input ready);
  modport sink   (input valid, input action, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic signed [lkv_pkg::VAL_W-1:0]    read_value;

  modport source (output valid, output found, output read_value, input ready);
  modport sink   (input valid, input found, input read_value, output ready);
endinterface

interface lkv_cfg_if;
  logic                                valid;
  logic                                ready;
  logic        [lkv_pkg::CAP_W-1:0]    capacity_in_use;

  modport source (output valid, output capacity_in_use, input ready);
  modport sink   (input valid, input capacity_in_use, output ready);
endinterface

>>> rtl/lkv_ram.sv
// ----------------------------------------------------------------------------
// lkv_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                     wdata,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer: accept, search, update, then hand over the result of a get.
// ----------------------------------------------------------------------------
module lkv_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output lkv_pkg::lkv_cmd_t    cmd,
  input  lkv_pkg::lkv_status_t status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE,
    S_RESULT
  } state_t;

  state_t state;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && req_valid;
    cmd.search = (state == S_SEARCH);
    cmd.update = (state == S_UPDATE);
    // output register free or being emptied this cycle
    cmd.result = (state == S_RESULT) && (!rsp_valid || rsp_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // a new result may replace the one leaving in the same cycle
      if (cmd.result) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          state <= (status.is_put == lkv_pkg::ACT_PUT) ? S_IDLE : S_RESULT;
        end
        S_RESULT: begin
          if (cmd.result) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/lkv_datapath.sv
// ----------------------------------------------------------------------------
// lkv_datapath
// Key match array, recency ranks, occupancy, value RAM and result register.
// ----------------------------------------------------------------------------
module lkv_datapath #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lkv_pkg::lkv_cmd_t                 cmd,
  output lkv_pkg::lkv_status_t              status,
  input  logic                              in_action,
  input  logic        [lkv_pkg::KEY_W-1:0]  in_key,
  input  logic        [lkv_pkg::VAL_W-1:0]  in_value,
  input  logic                              cap_we,
  input  logic        [lkv_pkg::CAP_W-1:0]  cap_data,
  output logic                              found,
  output logic        [lkv_pkg::VAL_W-1:0]  read_value
);

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;

  // item registers
  logic                        act_q;
  logic [lkv_pkg::KEY_W-1:0]   key_q;
  logic [lkv_pkg::VAL_W-1:0]   val_q;

  // stored state
  logic [lkv_pkg::CAP_W-1:0]   capacity;
  logic [lkv_pkg::KEY_W-1:0]   entry_key [ENTRIES];
  logic [IW-1:0]               rank      [ENTRIES];
  logic [CW-1:0]               occ;

  // search results
  logic [ENTRIES-1:0]          match_q;
  logic [ENTRIES-1:0]          victim_q;
  logic                        free_q;
  logic                        hit_q;

  logic [ENTRIES-1:0]          valid;
  logic [CW-1:0]               occ_m1;
  logic [lkv_pkg::CAP_W-1:0]   cap_lo;
  logic                        free_now;
  logic [IW-1:0]               hit_idx;
  logic [IW-1:0]               victim_idx;
  logic [IW-1:0]               hit_rank;
  logic [IW-1:0]               sel;
  logic [IW-1:0]               sel_rank;
  logic [lkv_pkg::VAL_W-1:0]   ram_rdata;
  logic                        ram_we;
  logic                        ram_re;

  assign status.is_put = act_q;

  // slots fill in index order and are never freed, so valid is a prefix
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid[i] = (CW'(i) < occ);
    end
  end

  assign occ_m1   = occ - CW'(1);
  assign cap_lo   = (capacity == '0) ? lkv_pkg::CAP_W'(1) : capacity;
  assign free_now = (occ != CW'(ENTRIES)) && (CMPW'(occ) < CMPW'(cap_lo));

  // one-hot to index and rank of the hit, and to index of the victim
  always_comb begin
    hit_idx    = '0;
    victim_idx = '0;
    hit_rank   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_q[i]) begin
        hit_idx  = hit_idx | IW'(i);
        hit_rank = hit_rank | rank[i];
      end
      if (victim_q[i]) begin
        victim_idx = victim_idx | IW'(i);
      end
    end
  end

  // a free slot insert is a touch from rank occ: every valid entry ages
  always_comb begin
    priority if (hit_q) begin
      sel      = hit_idx;
      sel_rank = hit_rank;
    end else if (free_q) begin
      sel      = IW'(occ);
      sel_rank = IW'(occ);
    end else begin
      sel      = victim_idx;
      sel_rank = IW'(occ_m1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= in_action;
      key_q <= in_key;
      val_q <= in_value;
    end
    if (cmd.search) begin
      for (int i = 0; i < ENTRIES; i++) begin
        match_q[i]  <= valid[i] && (entry_key[i] == key_q);
        victim_q[i] <= valid[i] && (rank[i] == IW'(occ_m1));
      end
      free_q <= free_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      hit_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid[i] && (entry_key[i] == key_q)) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  // ranks and occupancy; a get that misses leaves them alone
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (cmd.update && (act_q || hit_q)) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IW'(i) == sel) begin
          rank[i] <= '0;
        end else if (valid[i] && (rank[i] < sel_rank)) begin
          rank[i] <= rank[i] + IW'(1);
        end
      end
      if (act_q && !hit_q && free_q) begin
        occ <= occ + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && act_q && !hit_q) begin
      entry_key[sel] <= key_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkv_pkg::CAP_RESET;
    end else if (cap_we) begin
      capacity <= cap_data;
    end
  end

  assign ram_we = cmd.update && act_q;
  assign ram_re = cmd.update && !act_q && hit_q;

  lkv_ram #(
    .WIDTH (lkv_pkg::VAL_W),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (sel),
    .wdata (val_q),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      found      <= hit_q;
      read_value <= hit_q ? ram_rdata : lkv_pkg::MISS_VALUE;
    end
  end

  a_occ_bound : assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(ENTRIES))
    else $error("occupancy above entry count");

  a_match_unique : assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> $onehot0(match_q))
    else $error("key matched in more than one slot");

  a_victim_unique : assert property (@(posedge clk) disable iff (rst)
    (cmd.update && occ != '0) |-> $onehot(victim_q))
    else $error("no single least recent entry");

  a_occ_grow : assert property (@(posedge clk) disable iff (rst)
    (cmd.update && act_q && !hit_q && free_q) |=> (occ == $past(occ) + CW'(1)))
    else $error("insert into free slot did not grow occupancy");

endmodule

>>> rtl/lru_key_value_store.sv
// ----------------------------------------------------------------------------
// lru_key_value_store
// Fully associative key/value store with least-recently-used replacement.
//
//   channel  dir  payload                          one item is
//   req      in   action, key, value               a get or a put
//   rsp      out  found, read_value                the answer to a get
//   cfg      in   capacity_in_use                  a capacity write
//
// a put returns to ready after the rank update, a get after the result load; the
// sequence is accept, parallel key compare, rank update with value ram
// access, result load. a new item is taken while a result still waits.
// reset is synchronous; occupancy and ranks clear, capacity returns to 16.
// a get stalls in its last step only while the result register is full and not being emptied.
// ----------------------------------------------------------------------------
module lru_key_value_store #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  lkv_req_if.sink       req,
  lkv_rsp_if.source     rsp,
  lkv_cfg_if.sink       cfg
);

  lkv_pkg::lkv_cmd_t    cmd;
  lkv_pkg::lkv_status_t status;

  // capacity writes are taken in any cycle
  assign cfg.ready = 1'b1;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  lkv_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_action  (req.action),
    .in_key     (req.key),
    .in_value   (req.value),
    .cap_we     (cfg.valid && cfg.ready),
    .cap_data   (cfg.capacity_in_use),
    .found      (rsp.found),
    .read_value (rsp.read_value)
  );

endmodule
